// ===== src/psp_pkg.sv =====
// Package for the pick stack: operation codes, field selectors and cell control types.
`timescale 1ns / 1ps

package psp_pkg;

  typedef enum logic [2:0] {
    OP_PUSH          = 3'd0,
    OP_POP           = 3'd1,
    OP_PEEK          = 3'd2,
    OP_PURGE_MOL     = 3'd3,
    OP_PURGE_RES     = 3'd4,
    OP_PURGE_ATOM    = 3'd5,
    OP_CLEAR         = 3'd6,
    OP_CONTAINS_RES  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    FLD_ATOM,
    FLD_RESIDUE,
    FLD_MOLECULE
  } field_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DOWN,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     keep;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ===== src/pick_stack_with_purge.sv =====
// Top level of the pick stack: command decode, scan sequencer and the row of cells.
//
//  channel  | signals                                          | transfer
//  ---------+--------------------------------------------------+---------------------------
//  command  | start, operation, *_handle, handles_valid, busy  | start high while busy low
//  result   | done, top_*, found, size_changed, entry_count,   | done high, one cycle,
//           | overflow                                         | cannot be held off
//
// Cell 0 holds the top of the stack. Push, pop, peek and clear, and purge and contains
// on an empty stack, finish when taken and their result is strobed on the following
// cycle. Otherwise purge and contains rotate the occupied cells through cell 0 once,
// one entry a cycle, keeping busy high throughout, and strobe the result the cycle after.
// Reset empties the stack at once; there is no clearing pass.
`timescale 1ns / 1ps

module pick_stack_with_purge #(
  parameter int STACK_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           operation,
  input  logic [HANDLE_WIDTH-1:0]              atom_handle,
  input  logic [HANDLE_WIDTH-1:0]              residue_handle,
  input  logic [HANDLE_WIDTH-1:0]              molecule_handle,
  input  logic                                 handles_valid,
  output logic                                 done,
  output logic [HANDLE_WIDTH-1:0]              top_atom,
  output logic [HANDLE_WIDTH-1:0]              top_residue,
  output logic [HANDLE_WIDTH-1:0]              top_molecule,
  output logic                                 found,
  output logic                                 size_changed,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     entry_count,
  output logic                                 overflow
);

  localparam int HW = HANDLE_WIDTH;
  localparam int EW = 3 * HANDLE_WIDTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  psp_pkg::state_t    state, state_next;
  psp_pkg::op_t       op;
  psp_pkg::cell_ctl_t cell_ctl;

  logic [EW-1:0] cell_entry [STACK_DEPTH];
  logic [EW-1:0] push_entry;
  logic [EW-1:0] head;
  logic [HW-1:0] head_atom, head_residue, head_molecule;

  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] remain, remain_next;
  logic [CW-1:0] win, win_next;
  logic [CW-1:0] ins_index;
  logic          hit, hit_next;
  logic [HW-1:0] key, key_next;
  psp_pkg::field_t kind, kind_next;
  logic          contains, contains_next;

  logic          accept, scan_req, last_step, head_match, keep_step;

  logic          done_next;
  logic [HW-1:0] top_atom_next, top_residue_next, top_molecule_next;
  logic          found_next, size_changed_next, overflow_next;
  logic [CW-1:0] entry_count_next;

  assign op         = psp_pkg::op_t'(operation);
  assign accept     = start && (state == psp_pkg::ST_IDLE);
  assign push_entry = {atom_handle, residue_handle, molecule_handle};
  assign head       = cell_entry[0];
  assign head_atom     = head[EW-1 -: HW];
  assign head_residue  = head[2*HW-1 -: HW];
  assign head_molecule = head[HW-1:0];
  assign last_step  = (remain == CW'(1));
  assign ins_index  = win - CW'(1);

  assign scan_req = (occ != '0) &&
                    ((op == psp_pkg::OP_PURGE_MOL) || (op == psp_pkg::OP_PURGE_RES) ||
                     (op == psp_pkg::OP_PURGE_ATOM) || (op == psp_pkg::OP_CONTAINS_RES));

  always_comb begin
    case (kind)
      psp_pkg::FLD_ATOM:    head_match = (head_atom == key);
      psp_pkg::FLD_RESIDUE: head_match = (head_residue == key);
      default:              head_match = (head_molecule == key);
    endcase
  end

  assign keep_step = contains || !head_match;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      psp_pkg::ST_IDLE: begin
        if (accept && scan_req) begin
          state_next = psp_pkg::ST_SCAN;
        end
      end
      psp_pkg::ST_SCAN: begin
        if (last_step) begin
          state_next = psp_pkg::ST_IDLE;
        end
      end
      default: state_next = psp_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    case (state)
      psp_pkg::ST_SCAN: busy = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    cell_ctl.op       = psp_pkg::CELL_HOLD;
    cell_ctl.keep     = 1'b0;
    occ_next          = occ;
    remain_next       = remain;
    win_next          = win;
    hit_next          = hit;
    key_next          = key;
    kind_next         = kind;
    contains_next     = contains;
    done_next         = 1'b0;
    top_atom_next     = '0;
    top_residue_next  = '0;
    top_molecule_next = '0;
    found_next        = 1'b0;
    size_changed_next = 1'b0;
    overflow_next     = 1'b0;
    entry_count_next  = occ;

    if (state == psp_pkg::ST_SCAN) begin
      cell_ctl.op   = psp_pkg::CELL_ROT;
      cell_ctl.keep = keep_step;
      win_next      = keep_step ? win : (win - CW'(1));
      hit_next      = hit || (contains && head_match);
      remain_next   = remain - CW'(1);
      if (last_step) begin
        done_next         = 1'b1;
        occ_next          = win_next;
        entry_count_next  = win_next;
        size_changed_next = (win_next != occ);
        found_next        = hit_next;
      end
    end else if (accept) begin
      done_next     = !scan_req;
      remain_next   = occ;
      win_next      = occ;
      hit_next      = 1'b0;
      contains_next = (op == psp_pkg::OP_CONTAINS_RES);
      case (op)
        psp_pkg::OP_PUSH: begin
          if (handles_valid) begin
            if (occ < CW'(STACK_DEPTH)) begin
              cell_ctl.op       = psp_pkg::CELL_UP;
              occ_next          = occ + CW'(1);
              size_changed_next = 1'b1;
            end else begin
              overflow_next = 1'b1;
            end
          end
        end
        psp_pkg::OP_POP, psp_pkg::OP_PEEK: begin
          if (occ != '0) begin
            top_atom_next     = head_atom;
            top_residue_next  = head_residue;
            top_molecule_next = head_molecule;
            found_next        = 1'b1;
            if (op == psp_pkg::OP_POP) begin
              cell_ctl.op       = psp_pkg::CELL_DOWN;
              occ_next          = occ - CW'(1);
              size_changed_next = 1'b1;
            end
          end
        end
        psp_pkg::OP_PURGE_MOL: begin
          key_next  = molecule_handle;
          kind_next = psp_pkg::FLD_MOLECULE;
        end
        psp_pkg::OP_PURGE_RES, psp_pkg::OP_CONTAINS_RES: begin
          key_next  = residue_handle;
          kind_next = psp_pkg::FLD_RESIDUE;
        end
        psp_pkg::OP_PURGE_ATOM: begin
          key_next  = atom_handle;
          kind_next = psp_pkg::FLD_ATOM;
        end
        psp_pkg::OP_CLEAR: begin
          occ_next          = '0;
          size_changed_next = (occ != '0);
        end
        default: begin
          key_next = key;
        end
      endcase
      entry_count_next = occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psp_pkg::ST_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    remain       <= remain_next;
    win          <= win_next;
    hit          <= hit_next;
    key          <= key_next;
    kind         <= kind_next;
    contains     <= contains_next;
    top_atom     <= top_atom_next;
    top_residue  <= top_residue_next;
    top_molecule <= top_molecule_next;
    found        <= found_next;
    size_changed <= size_changed_next;
    overflow     <= overflow_next;
    entry_count  <= entry_count_next;
  end

  // Row of cells; the bottom cell reloads itself when the stack shifts towards the top.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [EW-1:0] prev_e, next_e;
    if (i == 0) begin : g_first
      assign prev_e = push_entry;
    end else begin : g_mid_prev
      assign prev_e = cell_entry[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_e = cell_entry[i];
    end else begin : g_mid_next
      assign next_e = cell_entry[i+1];
    end
    psp_cell #(
      .ENTRY_WIDTH (EW),
      .COUNT_WIDTH (CW),
      .INDEX       (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .ins_index  (ins_index),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .head_entry (head),
      .entry      (cell_entry[i])
    );
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(STACK_DEPTH))
    else $error("occupancy exceeds stack depth");

  a_window: assert property (@(posedge clk) disable iff (rst)
    busy |-> (win >= remain) && (remain != '0) && (win <= occ))
    else $error("scan window inconsistent with remaining steps");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while a scan is running");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (entry_count == CW'(STACK_DEPTH)) && !size_changed)
    else $error("overflow reported on a stack that is not full");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == psp_pkg::OP_POP) && (occ == '0))
      |=> done && !found && !size_changed)
    else $error("pop of an empty stack changed state");

endmodule

// ===== src/psp_cell.sv =====
// One stack cell: holds a single entry and loads from its neighbours or the head.
`timescale 1ns / 1ps

module psp_cell #(
  parameter int ENTRY_WIDTH = 48,
  parameter int COUNT_WIDTH = 5,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  psp_pkg::cell_ctl_t     ctl,
  input  logic [COUNT_WIDTH-1:0] ins_index,
  input  logic [ENTRY_WIDTH-1:0] prev_entry,
  input  logic [ENTRY_WIDTH-1:0] next_entry,
  input  logic [ENTRY_WIDTH-1:0] head_entry,
  output logic [ENTRY_WIDTH-1:0] entry
);

  logic [ENTRY_WIDTH-1:0] entry_next;

  always_comb begin
    case (ctl.op)
      psp_pkg::CELL_UP:   entry_next = prev_entry;
      psp_pkg::CELL_DOWN: entry_next = next_entry;
      psp_pkg::CELL_ROT: begin
        // The cell at the back of the window takes the departing head when it is kept.
        if (ctl.keep && (ins_index == COUNT_WIDTH'(INDEX))) begin
          entry_next = head_entry;
        end else begin
          entry_next = next_entry;
        end
      end
      default:            entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== tb/pick_stack_checker.sv =====
// Checker for the pick stack: predicts every result and compares it with the block.
`timescale 1ns / 1ps

module pick_stack_checker #(
  parameter int STACK_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [2:0]              operation,
  input  logic [HANDLE_WIDTH-1:0] atom_handle,
  input  logic [HANDLE_WIDTH-1:0] residue_handle,
  input  logic [HANDLE_WIDTH-1:0] molecule_handle,
  input  logic                    handles_valid,
  input  logic                    done,
  input  logic [HANDLE_WIDTH-1:0] top_atom,
  input  logic [HANDLE_WIDTH-1:0] top_residue,
  input  logic [HANDLE_WIDTH-1:0] top_molecule,
  input  logic                    found,
  input  logic                    size_changed,
  input  logic [CW-1:0]           entry_count,
  input  logic                    overflow,
  output int                      fail_count,
  output int                      pending,
  output int                      overflows_seen
);

  typedef struct {
    psp_pkg::op_t            op;
    logic [HANDLE_WIDTH-1:0] atom;
    logic [HANDLE_WIDTH-1:0] residue;
    logic [HANDLE_WIDTH-1:0] molecule;
    logic                    found;
    logic                    changed;
    logic [CW-1:0]           count;
    logic                    ovf;
  } stack_reply_t;

  logic [HANDLE_WIDTH-1:0] stk_atom [STACK_DEPTH];
  logic [HANDLE_WIDTH-1:0] stk_res  [STACK_DEPTH];
  logic [HANDLE_WIDTH-1:0] stk_mol  [STACK_DEPTH];
  int                      stk_fill;
  stack_reply_t            replies_due[$];
  int                      mismatches;
  int                      ovf_total;

  // Applies one command to the local copy of the stack; index 0 is the bottom.
  function automatic stack_reply_t stack_apply(psp_pkg::op_t op,
                                               logic [HANDLE_WIDTH-1:0] a,
                                               logic [HANDLE_WIDTH-1:0] r,
                                               logic [HANDLE_WIDTH-1:0] m, logic v);
    stack_reply_t            rep;
    int                      kept;
    int                      i;
    logic [HANDLE_WIDTH-1:0] key;
    logic [HANDLE_WIDTH-1:0] cur;
    rep.op       = op;
    rep.atom     = '0;
    rep.residue  = '0;
    rep.molecule = '0;
    rep.found    = 1'b0;
    rep.changed  = 1'b0;
    rep.ovf      = 1'b0;
    case (op)
      psp_pkg::OP_PUSH: begin
        if (v) begin
          if (stk_fill >= STACK_DEPTH) begin
            rep.ovf = 1'b1;
          end else begin
            stk_atom[stk_fill] = a;
            stk_res[stk_fill]  = r;
            stk_mol[stk_fill]  = m;
            stk_fill++;
            rep.changed = 1'b1;
          end
        end
      end
      psp_pkg::OP_POP, psp_pkg::OP_PEEK: begin
        if (stk_fill > 0) begin
          rep.atom     = stk_atom[stk_fill-1];
          rep.residue  = stk_res[stk_fill-1];
          rep.molecule = stk_mol[stk_fill-1];
          rep.found    = 1'b1;
          if (op == psp_pkg::OP_POP) begin
            stk_fill--;
            rep.changed = 1'b1;
          end
        end
      end
      psp_pkg::OP_PURGE_MOL, psp_pkg::OP_PURGE_RES, psp_pkg::OP_PURGE_ATOM: begin
        key  = (op == psp_pkg::OP_PURGE_MOL) ? m : (op == psp_pkg::OP_PURGE_RES) ? r : a;
        kept = 0;
        // Survivors slide down over the removed entries, keeping their order.
        for (i = 0; i < stk_fill; i++) begin
          cur = (op == psp_pkg::OP_PURGE_MOL) ? stk_mol[i] :
                (op == psp_pkg::OP_PURGE_RES) ? stk_res[i] : stk_atom[i];
          if (cur != key) begin
            stk_atom[kept] = stk_atom[i];
            stk_res[kept]  = stk_res[i];
            stk_mol[kept]  = stk_mol[i];
            kept++;
          end
        end
        rep.changed = (kept != stk_fill);
        stk_fill    = kept;
      end
      psp_pkg::OP_CLEAR: begin
        rep.changed = (stk_fill != 0);
        stk_fill    = 0;
      end
      default: begin
        for (i = 0; i < stk_fill; i++) begin
          if (stk_res[i] == r) rep.found = 1'b1;
        end
      end
    endcase
    rep.count = CW'(stk_fill);
    return rep;
  endfunction

  always @(posedge clk) begin
    stack_reply_t want;
    if (rst) begin
      stk_fill = 0;
      replies_due.delete();
    end else begin
      // A result always belongs to an earlier transfer, so it is checked first.
      if (done) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing outstanding (count %0d)", $realtime,
                     entry_count);
          end
        end else begin
          want = replies_due.pop_front();
          if (top_atom !== want.atom || top_residue !== want.residue ||
              top_molecule !== want.molecule || found !== want.found ||
              size_changed !== want.changed || entry_count !== want.count ||
              overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: %s expected a=%h r=%h m=%h fnd=%b chg=%b cnt=%0d ovf=%b",
                       $realtime, want.op.name(), want.atom, want.residue, want.molecule,
                       want.found, want.changed, want.count, want.ovf);
              $display("%0t: %s actual   a=%h r=%h m=%h fnd=%b chg=%b cnt=%0d ovf=%b",
                       $realtime, want.op.name(), top_atom, top_residue, top_molecule,
                       found, size_changed, entry_count, overflow);
            end
          end
          if (want.ovf) ovf_total++;
        end
      end
      if (start && !busy) begin
        replies_due.insert(replies_due.size(),
                           stack_apply(psp_pkg::op_t'(operation), atom_handle,
                                       residue_handle, molecule_handle, handles_valid));
      end
    end
    fail_count     <= mismatches;
    pending        <= replies_due.size();
    overflows_seen <= ovf_total;
  end

endmodule

// ===== tb/pick_stack_with_purge_tb.sv =====
// Testbench top for the pick stack: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps

module pick_stack_with_purge_tb;

  localparam int STACK_DEPTH    = 16;
  localparam int HANDLE_WIDTH   = 16;
  localparam int CW             = $clog2(STACK_DEPTH + 1);
  localparam int RANDOM_ITEMS   = 1100;
  localparam int QUIET_TAIL     = 150;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [2:0]              operation;
  logic [HANDLE_WIDTH-1:0] atom_handle;
  logic [HANDLE_WIDTH-1:0] residue_handle;
  logic [HANDLE_WIDTH-1:0] molecule_handle;
  logic                    handles_valid;
  logic                    done;
  logic [HANDLE_WIDTH-1:0] top_atom;
  logic [HANDLE_WIDTH-1:0] top_residue;
  logic [HANDLE_WIDTH-1:0] top_molecule;
  logic                    found;
  logic                    size_changed;
  logic [CW-1:0]           entry_count;
  logic                    overflow;

  int                      fail_count;
  int                      pending;
  int                      overflows_seen;
  int                      idle_cycles;
  int                      op_seen [8];
  bit                      gaps_on;
  logic [HANDLE_WIDTH-1:0] handle_pool [4];

  pick_stack_with_purge #(
    .STACK_DEPTH (STACK_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .atom_handle    (atom_handle),
    .residue_handle (residue_handle),
    .molecule_handle(molecule_handle),
    .handles_valid  (handles_valid),
    .done           (done),
    .top_atom       (top_atom),
    .top_residue    (top_residue),
    .top_molecule   (top_molecule),
    .found          (found),
    .size_changed   (size_changed),
    .entry_count    (entry_count),
    .overflow       (overflow)
  );

  pick_stack_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .atom_handle    (atom_handle),
    .residue_handle (residue_handle),
    .molecule_handle(molecule_handle),
    .handles_valid  (handles_valid),
    .done           (done),
    .top_atom       (top_atom),
    .top_residue    (top_residue),
    .top_molecule   (top_molecule),
    .found          (found),
    .size_changed   (size_changed),
    .entry_count    (entry_count),
    .overflow       (overflow),
    .fail_count     (fail_count),
    .pending        (pending),
    .overflows_seen (overflows_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is ended if neither a command nor a result is transferred for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Presents one command from a falling edge and holds it until it is taken.
  task automatic issue(input psp_pkg::op_t op, input logic [HANDLE_WIDTH-1:0] a,
                       input logic [HANDLE_WIDTH-1:0] r, input logic [HANDLE_WIDTH-1:0] m,
                       input logic v);
    if (gaps_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    start           <= 1'b1;
    operation       <= op;
    atom_handle     <= a;
    residue_handle  <= r;
    molecule_handle <= m;
    handles_valid   <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    op_seen[op]++;
    @(negedge clk);
  endtask

  // Half the handles come from a small pool, so that purges and queries find matches.
  function automatic logic [HANDLE_WIDTH-1:0] pick_handle();
    case ($urandom_range(9))
      0:             return '0;
      1:             return '1;
      2, 3, 4, 5, 6: return handle_pool[$urandom_range(3)];
      default:       return HANDLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic psp_pkg::op_t pick_op(int push_share);
    psp_pkg::op_t op;
    if ($urandom_range(99) < push_share) return psp_pkg::OP_PUSH;
    op = psp_pkg::op_t'($urandom_range(7, 1));
    // Clearing empties everything, so it is kept rarer than the other commands.
    if (op == psp_pkg::OP_CLEAR && $urandom_range(2) != 0) op = psp_pkg::OP_CONTAINS_RES;
    return op;
  endfunction

  initial begin
    int           k;
    int           push_share;
    psp_pkg::op_t op;
    rst             = 1'b1;
    start           = 1'b0;
    operation       = psp_pkg::OP_PUSH;
    atom_handle     = '0;
    residue_handle  = '0;
    molecule_handle = '0;
    handles_valid   = 1'b0;
    gaps_on         = 1'b1;
    foreach (op_seen[i]) op_seen[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Commands on an empty stack change nothing and return zeros.
    issue(psp_pkg::OP_POP, '0, '0, '0, 1'b1);
    issue(psp_pkg::OP_PEEK, '1, '1, '1, 1'b1);
    issue(psp_pkg::OP_CLEAR, '0, '0, '0, 1'b0);
    issue(psp_pkg::OP_CONTAINS_RES, '1, '0, '1, 1'b1);
    issue(psp_pkg::OP_PURGE_MOL, '0, '0, '0, 1'b1);
    issue(psp_pkg::OP_PUSH, '0, '0, '0, 1'b1);
    issue(psp_pkg::OP_PUSH, '1, '1, '1, 1'b1);
    issue(psp_pkg::OP_PUSH, 16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    issue(psp_pkg::OP_PEEK, '0, '0, '0, 1'b0);
    issue(psp_pkg::OP_CONTAINS_RES, '1, '0, '1, 1'b1);
    issue(psp_pkg::OP_PURGE_ATOM, 16'h5555, '1, '0, 1'b1);
    issue(psp_pkg::OP_PURGE_RES, '0, '1, '0, 1'b1);
    issue(psp_pkg::OP_POP, '0, '0, '0, 1'b1);
    // Fill the stack with two interleaved molecules, then push past the top.
    for (k = 0; k < STACK_DEPTH; k++) begin
      issue(psp_pkg::OP_PUSH, HANDLE_WIDTH'(k), (k % 2 == 1) ? '1 : HANDLE_WIDTH'(k),
            (k % 2 == 1) ? 16'h8001 : 16'h7FFE, 1'b1);
    end
    issue(psp_pkg::OP_PUSH, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    issue(psp_pkg::OP_PUSH, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    issue(psp_pkg::OP_PURGE_MOL, '0, '0, 16'h8001, 1'b1);
    issue(psp_pkg::OP_PEEK, '0, '0, '0, 1'b1);
    issue(psp_pkg::OP_CONTAINS_RES, '0, '1, '0, 1'b1);
    issue(psp_pkg::OP_CLEAR, '1, '1, '1, 1'b1);

    push_share = 35;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // Every hundred commands the mix leans towards filling, balance or draining.
      if (k % 100 == 0) begin
        case ($urandom_range(2))
          0:       push_share = 65;
          1:       push_share = 35;
          default: push_share = 15;
        endcase
        handle_pool[0] = HANDLE_WIDTH'($urandom_range(7));
        handle_pool[1] = HANDLE_WIDTH'($urandom_range(7));
        handle_pool[2] = HANDLE_WIDTH'($urandom);
        handle_pool[3] = HANDLE_WIDTH'($urandom);
      end
      if (k == RANDOM_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
      op = pick_op(push_share);
      issue(op, pick_handle(), pick_handle(), pick_handle(), $urandom_range(9) != 0);
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (STACK_DEPTH + 4) @(negedge clk);

    $display("Ran %0d pushes (%0d overflowed), %0d pops, %0d peeks, %0d clears",
             op_seen[psp_pkg::OP_PUSH], overflows_seen, op_seen[psp_pkg::OP_POP],
             op_seen[psp_pkg::OP_PEEK], op_seen[psp_pkg::OP_CLEAR]);
    $display("and %0d purges by molecule, residue and atom, %0d residue queries",
             op_seen[psp_pkg::OP_PURGE_MOL] + op_seen[psp_pkg::OP_PURGE_RES] +
             op_seen[psp_pkg::OP_PURGE_ATOM], op_seen[psp_pkg::OP_CONTAINS_RES]);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/psp_pkg.sv
src/psp_cell.sv
src/pick_stack_with_purge.sv
tb/pick_stack_checker.sv
tb/pick_stack_with_purge_tb.sv
